// ===== rtl/popc_pkg.sv =====
// Shared types and constants for the planar odometry pose composer.
// No dependencies; used by popc_cordic, popc_rotate and the top level.
package popc_pkg;

    // CORDIC angle accumulator: 32-bit binary angle plus guard bits
    localparam int ANG32_W = 32;
    localparam int ZW      = ANG32_W + 2;
    typedef logic signed [ZW-1:0] zang_t;

    // sine / cosine in Q30
    localparam int CS_W = 32;
    typedef logic signed [CS_W-1:0] trig_t;

    localparam trig_t GAIN_Q30     = 32'sd652032874;
    localparam zang_t QUARTER_TURN = 34'sd1073741824;

    // arctan(2^-i) in 32-bit binary angle units
    localparam int ATAN_DEPTH = 24;
    localparam zang_t ATAN_TABLE [ATAN_DEPTH] = '{
        34'sd536870912, 34'sd316933406, 34'sd167458907, 34'sd85004756,
        34'sd42667331,  34'sd21354465,  34'sd10679838,  34'sd5340245,
        34'sd2670163,   34'sd1335087,   34'sd667544,    34'sd333772,
        34'sd166886,    34'sd83443,     34'sd41722,     34'sd20861,
        34'sd10430,     34'sd5215,      34'sd2608,      34'sd1304,
        34'sd652,       34'sd326,       34'sd163,       34'sd81
    };

    // translation split into high and low halves for the products
    localparam int SPLIT_W = 48;
    localparam int LO_BITS = 24;
    localparam int HI_W    = SPLIT_W - LO_BITS;
    localparam int LO_W    = LO_BITS + 1;

    localparam int PH_W   = HI_W + CS_W;
    localparam int PL_W   = LO_W + CS_W;
    localparam int HSUM_W = PH_W + 1;
    localparam int LSUM_W = PL_W + 1;
    localparam int TSUM_W = HSUM_W + 1;

    localparam int Q30_SHIFT  = 30;
    localparam int POST_SHIFT = Q30_SHIFT - LO_BITS;
    localparam int TERM_W     = TSUM_W - POST_SHIFT;
    localparam int SUM_W      = TERM_W + 1;

    localparam logic signed [LSUM_W-1:0] ROUND_HALF = LSUM_W'(2 ** (Q30_SHIFT - 1));

endpackage

// ===== rtl/popc_cordic.sv =====
// Pipelined CORDIC: one rotation per stage, yields cos, sin and -sin in Q30.
// Carries the pose payload alongside. Depends on popc_pkg.
module popc_cordic #(
    parameter int POS_WIDTH    = 32,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic                          in_valid,
    input  logic signed [POS_WIDTH-1:0]   start_x,
    input  logic signed [POS_WIDTH-1:0]   start_y,
    input  logic signed [ANGLE_WIDTH-1:0] start_heading,
    input  logic signed [POS_WIDTH-1:0]   move_forward,
    input  logic signed [POS_WIDTH-1:0]   move_lateral,
    input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
    output logic                          trig_valid,
    output popc_pkg::trig_t               cos_val,
    output popc_pkg::trig_t               sin_val,
    output popc_pkg::trig_t               nsin_val,
    output logic signed [POS_WIDTH-1:0]   pos_x,
    output logic signed [POS_WIDTH-1:0]   pos_y,
    output logic signed [POS_WIDTH-1:0]   fwd,
    output logic signed [POS_WIDTH-1:0]   lat,
    output logic signed [ANGLE_WIDTH-1:0] heading
);

    localparam int LAST = CORDIC_STEPS + 1;

    logic [LAST:0]                  valid_reg;
    popc_pkg::trig_t                x_reg   [0:LAST];
    popc_pkg::trig_t                y_reg   [0:LAST];
    popc_pkg::trig_t                ny_reg  [0:LAST];
    popc_pkg::zang_t                z_reg   [0:LAST];
    logic                           flip_reg[0:LAST];
    logic signed [POS_WIDTH-1:0]    sx_reg  [0:LAST];
    logic signed [POS_WIDTH-1:0]    sy_reg  [0:LAST];
    logic signed [POS_WIDTH-1:0]    fwd_reg [0:LAST];
    logic signed [POS_WIDTH-1:0]    lat_reg [0:LAST];
    logic signed [ANGLE_WIDTH-1:0]  hd_reg  [0:LAST];

    logic [popc_pkg::ANG32_W-1:0]   ang32;
    logic                           flip_next;
    logic [popc_pkg::ANG32_W-1:0]   folded;
    popc_pkg::zang_t                z0_next;

    // fold quadrants II/III into IV/I by a half turn
    always_comb
    begin
        ang32     = {start_heading, {(popc_pkg::ANG32_W - ANGLE_WIDTH){1'b0}}};
        flip_next = ang32[popc_pkg::ANG32_W-1] ^ ang32[popc_pkg::ANG32_W-2];
        folded    = {ang32[popc_pkg::ANG32_W-1] ^ flip_next, ang32[popc_pkg::ANG32_W-2:0]};
        z0_next   = popc_pkg::zang_t'(signed'(folded));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[LAST-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[0]    <= popc_pkg::GAIN_Q30;
            y_reg[0]    <= '0;
            ny_reg[0]   <= '0;
            z_reg[0]    <= z0_next;
            flip_reg[0] <= flip_next;
            sx_reg[0]   <= start_x;
            sy_reg[0]   <= start_y;
            fwd_reg[0]  <= move_forward;
            lat_reg[0]  <= move_lateral;
            hd_reg[0]   <= start_heading + turn_angle;
        end
    end

    for (genvar i = 1; i <= CORDIC_STEPS; i++)
    begin : g_iter
        localparam int J = i - 1;
        popc_pkg::trig_t x_next;
        popc_pkg::trig_t y_next;
        popc_pkg::zang_t z_next;

        always_comb
        begin
            if (!z_reg[i-1][popc_pkg::ZW-1])
            begin
                x_next = x_reg[i-1] - (y_reg[i-1] >>> J);
                y_next = y_reg[i-1] + (x_reg[i-1] >>> J);
                z_next = z_reg[i-1] - popc_pkg::ATAN_TABLE[J];
            end
            else
            begin
                x_next = x_reg[i-1] + (y_reg[i-1] >>> J);
                y_next = y_reg[i-1] - (x_reg[i-1] >>> J);
                z_next = z_reg[i-1] + popc_pkg::ATAN_TABLE[J];
            end
        end

        always_ff @(posedge clk)
        begin
            if (advance)
            begin
                x_reg[i]    <= x_next;
                y_reg[i]    <= y_next;
                ny_reg[i]   <= '0;
                z_reg[i]    <= z_next;
                flip_reg[i] <= flip_reg[i-1];
                sx_reg[i]   <= sx_reg[i-1];
                sy_reg[i]   <= sy_reg[i-1];
                fwd_reg[i]  <= fwd_reg[i-1];
                lat_reg[i]  <= lat_reg[i-1];
                hd_reg[i]   <= hd_reg[i-1];
            end
        end
    end

    // undo the half-turn fold; also form -sin for the x row
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            x_reg[LAST]    <= flip_reg[LAST-1] ? -x_reg[LAST-1] : x_reg[LAST-1];
            y_reg[LAST]    <= flip_reg[LAST-1] ? -y_reg[LAST-1] : y_reg[LAST-1];
            ny_reg[LAST]   <= flip_reg[LAST-1] ? y_reg[LAST-1] : -y_reg[LAST-1];
            z_reg[LAST]    <= z_reg[LAST-1];
            flip_reg[LAST] <= flip_reg[LAST-1];
            sx_reg[LAST]   <= sx_reg[LAST-1];
            sy_reg[LAST]   <= sy_reg[LAST-1];
            fwd_reg[LAST]  <= fwd_reg[LAST-1];
            lat_reg[LAST]  <= lat_reg[LAST-1];
            hd_reg[LAST]   <= hd_reg[LAST-1];
        end
    end

    assign trig_valid = valid_reg[LAST];
    assign cos_val    = x_reg[LAST];
    assign sin_val    = y_reg[LAST];
    assign nsin_val   = ny_reg[LAST];
    assign pos_x      = sx_reg[LAST];
    assign pos_y      = sy_reg[LAST];
    assign fwd        = fwd_reg[LAST];
    assign lat        = lat_reg[LAST];
    assign heading    = hd_reg[LAST];

    // residual angle bound after the last rotation
    localparam popc_pkg::zang_t Z_BOUND =
        popc_pkg::ATAN_TABLE[CORDIC_STEPS-1] + popc_pkg::ATAN_TABLE[CORDIC_STEPS-1]
        + popc_pkg::zang_t'(CORDIC_STEPS);

    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[0] |-> (z_reg[0] >= -popc_pkg::QUARTER_TURN)
                      && (z_reg[0] < popc_pkg::QUARTER_TURN))
        else $error("folded angle outside half turn");

    a_converged: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[CORDIC_STEPS] |-> (z_reg[CORDIC_STEPS] <= Z_BOUND)
                                 && (z_reg[CORDIC_STEPS] >= -Z_BOUND))
        else $error("CORDIC residual angle did not converge");

endmodule

// ===== rtl/popc_rotate.sv =====
// Rotates the body-frame translation by (cos, sin), adds the prior position,
// saturates, and drives the output register with a one-entry skid. Uses popc_pkg.
module popc_rotate #(
    parameter int POS_WIDTH   = 32,
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    output logic                          advance,
    input  logic                          trig_valid,
    input  popc_pkg::trig_t               cos_val,
    input  popc_pkg::trig_t               sin_val,
    input  popc_pkg::trig_t               nsin_val,
    input  logic signed [POS_WIDTH-1:0]   pos_x,
    input  logic signed [POS_WIDTH-1:0]   pos_y,
    input  logic signed [POS_WIDTH-1:0]   fwd,
    input  logic signed [POS_WIDTH-1:0]   lat,
    input  logic signed [ANGLE_WIDTH-1:0] heading,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   new_x,
    output logic signed [POS_WIDTH-1:0]   new_y,
    output logic signed [ANGLE_WIDTH-1:0] new_heading,
    output logic                          clipped
);

    localparam logic signed [POS_WIDTH-1:0] POS_MAX = {1'b0, {(POS_WIDTH-1){1'b1}}};
    localparam logic signed [POS_WIDTH-1:0] POS_MIN = {1'b1, {(POS_WIDTH-1){1'b0}}};

    // ---- split translations ----
    logic signed [popc_pkg::SPLIT_W-1:0] fwd_w, lat_w;
    logic signed [popc_pkg::HI_W-1:0]    fwd_hi, lat_hi;
    logic signed [popc_pkg::LO_W-1:0]    fwd_lo, lat_lo;

    always_comb
    begin
        fwd_w  = popc_pkg::SPLIT_W'(fwd);
        lat_w  = popc_pkg::SPLIT_W'(lat);
        fwd_hi = signed'(fwd_w[popc_pkg::SPLIT_W-1:popc_pkg::LO_BITS]);
        lat_hi = signed'(lat_w[popc_pkg::SPLIT_W-1:popc_pkg::LO_BITS]);
        fwd_lo = signed'({1'b0, fwd_w[popc_pkg::LO_BITS-1:0]});
        lat_lo = signed'({1'b0, lat_w[popc_pkg::LO_BITS-1:0]});
    end

    // ---- product stage ----
    logic                                p_valid_reg;
    logic signed [popc_pkg::PH_W-1:0]    xh_f_reg, xh_l_reg, yh_f_reg, yh_l_reg;
    logic signed [popc_pkg::PL_W-1:0]    xl_f_reg, xl_l_reg, yl_f_reg, yl_l_reg;
    logic signed [POS_WIDTH-1:0]         p_sx_reg, p_sy_reg;
    logic signed [ANGLE_WIDTH-1:0]       p_hd_reg;

    // ---- partial sum stage ----
    logic                                s_valid_reg;
    logic signed [popc_pkg::HSUM_W-1:0]  xh_reg, yh_reg;
    logic signed [popc_pkg::LSUM_W-1:0]  xl_reg, yl_reg;
    logic signed [POS_WIDTH-1:0]         s_sx_reg, s_sy_reg;
    logic signed [ANGLE_WIDTH-1:0]       s_hd_reg;

    // ---- rounded term stage ----
    logic                                r_valid_reg;
    logic signed [popc_pkg::TERM_W-1:0]  tx_reg, ty_reg;
    logic signed [POS_WIDTH-1:0]         r_sx_reg, r_sy_reg;
    logic signed [ANGLE_WIDTH-1:0]       r_hd_reg;

    logic signed [popc_pkg::TSUM_W-1:0]  tx_full, ty_full;

    // ---- output register and skid ----
    logic                                out_valid_reg, skid_valid_reg;
    logic signed [POS_WIDTH-1:0]         out_x_reg, out_y_reg, skid_x_reg, skid_y_reg;
    logic signed [ANGLE_WIDTH-1:0]       out_hd_reg, skid_hd_reg;
    logic                                out_clip_reg, skid_clip_reg;

    logic signed [popc_pkg::SUM_W-1:0]   sum_x, sum_y;
    logic signed [POS_WIDTH-1:0]         sat_x, sat_y;
    logic                                clip_x, clip_y;
    logic                                out_fire, arrive;

    assign advance  = !skid_valid_reg;
    assign out_fire = out_valid_reg && out_ready;
    assign arrive   = advance && r_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_valid_reg <= 1'b0;
            s_valid_reg <= 1'b0;
            r_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            p_valid_reg <= trig_valid;
            s_valid_reg <= p_valid_reg;
            r_valid_reg <= s_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xh_f_reg <= fwd_hi * cos_val;
            xh_l_reg <= lat_hi * nsin_val;
            xl_f_reg <= fwd_lo * cos_val;
            xl_l_reg <= lat_lo * nsin_val;
            yh_f_reg <= fwd_hi * sin_val;
            yh_l_reg <= lat_hi * cos_val;
            yl_f_reg <= fwd_lo * sin_val;
            yl_l_reg <= lat_lo * cos_val;
            p_sx_reg <= pos_x;
            p_sy_reg <= pos_y;
            p_hd_reg <= heading;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            xh_reg   <= popc_pkg::HSUM_W'(xh_f_reg) + popc_pkg::HSUM_W'(xh_l_reg);
            yh_reg   <= popc_pkg::HSUM_W'(yh_f_reg) + popc_pkg::HSUM_W'(yh_l_reg);
            xl_reg   <= popc_pkg::LSUM_W'(xl_f_reg) + popc_pkg::LSUM_W'(xl_l_reg)
                        + popc_pkg::ROUND_HALF;
            yl_reg   <= popc_pkg::LSUM_W'(yl_f_reg) + popc_pkg::LSUM_W'(yl_l_reg)
                        + popc_pkg::ROUND_HALF;
            s_sx_reg <= p_sx_reg;
            s_sy_reg <= p_sy_reg;
            s_hd_reg <= p_hd_reg;
        end
    end

    // fold the low half's carry into the high half, then drop to Q0
    always_comb
    begin
        tx_full = popc_pkg::TSUM_W'(xh_reg) + popc_pkg::TSUM_W'(xl_reg >>> popc_pkg::LO_BITS);
        ty_full = popc_pkg::TSUM_W'(yh_reg) + popc_pkg::TSUM_W'(yl_reg >>> popc_pkg::LO_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tx_reg   <= popc_pkg::TERM_W'(tx_full >>> popc_pkg::POST_SHIFT);
            ty_reg   <= popc_pkg::TERM_W'(ty_full >>> popc_pkg::POST_SHIFT);
            r_sx_reg <= s_sx_reg;
            r_sy_reg <= s_sy_reg;
            r_hd_reg <= s_hd_reg;
        end
    end

    always_comb
    begin
        sum_x  = popc_pkg::SUM_W'(r_sx_reg) + popc_pkg::SUM_W'(tx_reg);
        sum_y  = popc_pkg::SUM_W'(r_sy_reg) + popc_pkg::SUM_W'(ty_reg);
        clip_x = (sum_x > popc_pkg::SUM_W'(POS_MAX)) || (sum_x < popc_pkg::SUM_W'(POS_MIN));
        clip_y = (sum_y > popc_pkg::SUM_W'(POS_MAX)) || (sum_y < popc_pkg::SUM_W'(POS_MIN));
        if (sum_x > popc_pkg::SUM_W'(POS_MAX))
            sat_x = POS_MAX;
        else if (sum_x < popc_pkg::SUM_W'(POS_MIN))
            sat_x = POS_MIN;
        else
            sat_x = POS_WIDTH'(sum_x);
        if (sum_y > popc_pkg::SUM_W'(POS_MAX))
            sat_y = POS_MAX;
        else if (sum_y < popc_pkg::SUM_W'(POS_MIN))
            sat_y = POS_MIN;
        else
            sat_y = POS_WIDTH'(sum_y);
    end

    // skid: catches one result when the output register is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_fire)
                skid_valid_reg <= 1'b0;
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_ready)
                skid_valid_reg <= 1'b1;
            else
                out_valid_reg <= 1'b1;
        end
        else if (out_fire)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_x_reg    <= skid_x_reg;
                out_y_reg    <= skid_y_reg;
                out_hd_reg   <= skid_hd_reg;
                out_clip_reg <= skid_clip_reg;
            end
        end
        else if (arrive)
        begin
            if (out_valid_reg && !out_ready)
            begin
                skid_x_reg    <= sat_x;
                skid_y_reg    <= sat_y;
                skid_hd_reg   <= r_hd_reg;
                skid_clip_reg <= clip_x || clip_y;
            end
            else
            begin
                out_x_reg    <= sat_x;
                out_y_reg    <= sat_y;
                out_hd_reg   <= r_hd_reg;
                out_clip_reg <= clip_x || clip_y;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign new_x       = out_x_reg;
    assign new_y       = out_y_reg;
    assign new_heading = out_hd_reg;
    assign clipped     = out_clip_reg;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_clip_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_clip_reg) |->
            (out_x_reg == POS_MAX) || (out_x_reg == POS_MIN)
            || (out_y_reg == POS_MAX) || (out_y_reg == POS_MIN))
        else $error("clip flagged but no position at a rail");

endmodule

// ===== rtl/planar_odometry_pose_compose.sv =====
// Top level of the planar odometry pose composer (SE(2) motion model).
// Instantiates popc_cordic and popc_rotate; depends on popc_pkg.

// Composes a prior pose (x, y, heading) with a body-frame odometry step
// (forward, lateral, turn) and returns the new pose, one result per request.
// The block takes one request per clock and keeps that rate for as long as
// results are drained. A request passes CORDIC_STEPS + 6 register stages: one
// entry stage, one stage per CORDIC rotation, one stage to undo the quadrant
// fold, then product, partial sum, rounding and the add/saturate into the
// output register. The entry stage loads at the accepting edge. No stage holds
// more than one CORDIC rotation, one row of 24x32 and 25x32 multipliers or
// one wide add. A one-entry skid behind the output register lets a request
// be accepted in the cycle a result is stalled; in_ready drops only once
// that skid is occupied. Positions are signed fixed point in any Q format
// (the fraction cancels); the rotated offset is rounded half up and the sums
// saturate to the POS_WIDTH range, with clipped set when either coordinate
// hit a rail. Headings are binary angles (half of 2^ANGLE_WIDTH is pi) and
// wrap modulo a full turn.
module planar_odometry_pose_compose #(
    parameter int POS_WIDTH    = 32,
    parameter int ANGLE_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [POS_WIDTH-1:0]   start_x,
    input  logic signed [POS_WIDTH-1:0]   start_y,
    input  logic signed [ANGLE_WIDTH-1:0] start_heading,
    input  logic signed [POS_WIDTH-1:0]   move_forward,
    input  logic signed [POS_WIDTH-1:0]   move_lateral,
    input  logic signed [ANGLE_WIDTH-1:0] turn_angle,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [POS_WIDTH-1:0]   new_x,
    output logic signed [POS_WIDTH-1:0]   new_y,
    output logic signed [ANGLE_WIDTH-1:0] new_heading,
    output logic                          clipped
);

    // whole pipeline moves together; only the skid can stop it
    logic                          advance;

    logic                          trig_valid;
    popc_pkg::trig_t               cos_val;
    popc_pkg::trig_t               sin_val;
    popc_pkg::trig_t               nsin_val;
    logic signed [POS_WIDTH-1:0]   pos_x;
    logic signed [POS_WIDTH-1:0]   pos_y;
    logic signed [POS_WIDTH-1:0]   fwd;
    logic signed [POS_WIDTH-1:0]   lat;
    logic signed [ANGLE_WIDTH-1:0] heading;

    assign in_ready = advance;

    // sine/cosine of the prior heading, payload riding alongside
    popc_cordic #(
        .POS_WIDTH    (POS_WIDTH),
        .ANGLE_WIDTH  (ANGLE_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (advance),
        .in_valid      (in_valid),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_heading (start_heading),
        .move_forward  (move_forward),
        .move_lateral  (move_lateral),
        .turn_angle    (turn_angle),
        .trig_valid    (trig_valid),
        .cos_val       (cos_val),
        .sin_val       (sin_val),
        .nsin_val      (nsin_val),
        .pos_x         (pos_x),
        .pos_y         (pos_y),
        .fwd           (fwd),
        .lat           (lat),
        .heading       (heading)
    );

    // rotate the step into the world frame, add, saturate, output
    popc_rotate #(
        .POS_WIDTH   (POS_WIDTH),
        .ANGLE_WIDTH (ANGLE_WIDTH)
    ) u_rotate (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .trig_valid  (trig_valid),
        .cos_val     (cos_val),
        .sin_val     (sin_val),
        .nsin_val    (nsin_val),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .fwd         (fwd),
        .lat         (lat),
        .heading     (heading),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .new_x       (new_x),
        .new_y       (new_y),
        .new_heading (new_heading),
        .clipped     (clipped)
    );

endmodule

// ===== dv/planar_odometry_pose_compose_tb.sv =====
// Self-checking testbench for planar_odometry_pose_compose.
// Needs only the RTL under rtl/. A local bit-exact pose predictor or hand-typed
// rows check every result of a directed table and a random request stream.
module planar_odometry_pose_compose_tb;

    localparam int POS_W    = 32;
    localparam int ANG_W    = 16;
    localparam int CORDIC_N = 16;

    // input accept to output valid, plus margin for the output skid
    localparam int LATENCY      = CORDIC_N + 5;
    localparam int DRAIN_CYCLES = LATENCY + 20;

    localparam int RANDOM_REQUESTS = 600;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int MAX_REPORTS     = 10;

    localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

    // wide copies of the rails for the saturation compare
    localparam logic signed [95:0] RAIL_HI = 96'sd2147483647;
    localparam logic signed [95:0] RAIL_LO = -96'sd2147483648;

    localparam longint CORDIC_GAIN_Q30 = 64'sd652032874;
    localparam logic signed [95:0] HALF_LSB_Q30 = 96'sd536870912;

    typedef struct packed {
        logic signed [POS_W-1:0] start_x;
        logic signed [POS_W-1:0] start_y;
        logic signed [ANG_W-1:0] start_heading;
        logic signed [POS_W-1:0] move_forward;
        logic signed [POS_W-1:0] move_lateral;
        logic signed [ANG_W-1:0] turn_angle;
    } pose_req_t;

    typedef struct packed {
        logic signed [POS_W-1:0] new_x;
        logic signed [POS_W-1:0] new_y;
        logic signed [ANG_W-1:0] new_heading;
        logic                    clipped;
    } pose_res_t;

    // one line of the directed table; known rows carry a hand-typed result
    typedef struct packed {
        pose_req_t req;
        logic      known;
        pose_res_t want;
    } directed_row_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    logic signed [POS_W-1:0] start_x;
    logic signed [POS_W-1:0] start_y;
    logic signed [ANG_W-1:0] start_heading;
    logic signed [POS_W-1:0] move_forward;
    logic signed [POS_W-1:0] move_lateral;
    logic signed [ANG_W-1:0] turn_angle;
    logic                    out_valid;
    logic                    out_ready;
    logic signed [POS_W-1:0] new_x;
    logic signed [POS_W-1:0] new_y;
    logic signed [ANG_W-1:0] new_heading;
    logic                    clipped;

    pose_res_t expected_poses[$];

    int  requests_sent;
    int  directed_count;
    int  results_checked;
    int  clip_count;
    int  mismatch_count;
    int  idle_cycles;
    bit  steady_flow;   // both sides run without gaps while set

    planar_odometry_pose_compose #(
        .POS_WIDTH    (POS_W),
        .ANGLE_WIDTH  (ANG_W),
        .CORDIC_STEPS (CORDIC_N)
    ) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .start_x       (start_x),
        .start_y       (start_y),
        .start_heading (start_heading),
        .move_forward  (move_forward),
        .move_lateral  (move_lateral),
        .turn_angle    (turn_angle),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .new_x         (new_x),
        .new_y         (new_y),
        .new_heading   (new_heading),
        .clipped       (clipped)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // arctan(2^-i) as a 32-bit binary angle
    function automatic longint atan_turn(int i);
        case (i)
            0:       return 536870912;
            1:       return 316933406;
            2:       return 167458907;
            3:       return 85004756;
            4:       return 42667331;
            5:       return 21354465;
            6:       return 10679838;
            7:       return 5340245;
            8:       return 2670163;
            9:       return 1335087;
            10:      return 667544;
            11:      return 333772;
            12:      return 166886;
            13:      return 83443;
            14:      return 41722;
            15:      return 20861;
            default: return 0;
        endcase
    endfunction

    // New pose for one request. Heading is folded into [-pi/2, pi/2) before
    // the rotations and the signs of sin/cos restored afterwards; the rotated
    // offset is rounded half up out of Q30, then added and clamped.
    function automatic pose_res_t compose_pose(pose_req_t r);
        logic [31:0]        ang32;
        logic               fold;
        longint             zacc;
        longint             cos_q30;
        longint             sin_q30;
        longint             xs;
        longint             ys;
        logic signed [95:0] wf;
        logic signed [95:0] wl;
        logic signed [95:0] wc;
        logic signed [95:0] ws;
        logic signed [95:0] tot_x;
        logic signed [95:0] tot_y;
        pose_res_t          res;

        ang32 = {r.start_heading, {(32 - ANG_W){1'b0}}};
        fold  = (ang32[31:30] == 2'b01) || (ang32[31:30] == 2'b10);
        if (fold)
        begin
            ang32[31] = ~ang32[31];
        end
        zacc    = longint'($signed(ang32));
        cos_q30 = CORDIC_GAIN_Q30;
        sin_q30 = 0;
        for (int i = 0; i < CORDIC_N; i++)
        begin
            xs = cos_q30 >>> i;
            ys = sin_q30 >>> i;
            if (zacc >= 0)
            begin
                cos_q30 = cos_q30 - ys;
                sin_q30 = sin_q30 + xs;
                zacc    = zacc - atan_turn(i);
            end
            else
            begin
                cos_q30 = cos_q30 + ys;
                sin_q30 = sin_q30 - xs;
                zacc    = zacc + atan_turn(i);
            end
        end
        if (fold)
        begin
            cos_q30 = -cos_q30;
            sin_q30 = -sin_q30;
        end

        wf = $signed(r.move_forward);
        wl = $signed(r.move_lateral);
        wc = cos_q30;
        ws = sin_q30;
        tot_x = $signed(r.start_x);
        tot_y = $signed(r.start_y);
        tot_x = tot_x + ((wf * wc - wl * ws + HALF_LSB_Q30) >>> 30);
        tot_y = tot_y + ((wf * ws + wl * wc + HALF_LSB_Q30) >>> 30);

        res.clipped = 1'b0;
        if (tot_x > RAIL_HI)
        begin
            res.new_x   = POS_MAX;
            res.clipped = 1'b1;
        end
        else if (tot_x < RAIL_LO)
        begin
            res.new_x   = POS_MIN;
            res.clipped = 1'b1;
        end
        else
        begin
            res.new_x = tot_x[POS_W-1:0];
        end
        if (tot_y > RAIL_HI)
        begin
            res.new_y   = POS_MAX;
            res.clipped = 1'b1;
        end
        else if (tot_y < RAIL_LO)
        begin
            res.new_y   = POS_MIN;
            res.clipped = 1'b1;
        end
        else
        begin
            res.new_y = tot_y[POS_W-1:0];
        end
        res.new_heading = r.start_heading + r.turn_angle;   // wraps mod full turn
        return res;
    endfunction

    function automatic pose_req_t mk_req(
        input logic signed [POS_W-1:0] sx,
        input logic signed [POS_W-1:0] sy,
        input logic signed [ANG_W-1:0] hd,
        input logic signed [POS_W-1:0] fwd,
        input logic signed [POS_W-1:0] lat,
        input logic signed [ANG_W-1:0] turn
    );
        return {sx, sy, hd, fwd, lat, turn};
    endfunction

    function automatic pose_res_t mk_res(
        input logic signed [POS_W-1:0] nx,
        input logic signed [POS_W-1:0] ny,
        input logic signed [ANG_W-1:0] nh,
        input logic                    clip
    );
        return {nx, ny, nh, clip};
    endfunction

    // mostly back-to-back, some short gaps, now and then a long one
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 65)
        begin
            return 0;
        end
        if (roll < 93)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Drive one request and hold it until accepted; the expectation is queued
    // at the accepting edge.
    task automatic issue_request(input pose_req_t r, input pose_res_t want);
        in_valid      <= 1'b1;
        start_x       <= r.start_x;
        start_y       <= r.start_y;
        start_heading <= r.start_heading;
        move_forward  <= r.move_forward;
        move_lateral  <= r.move_lateral;
        turn_angle    <= r.turn_angle;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        expected_poses.push_back(want);
        requests_sent++;
    endtask

    // valid only drops when a gap is taken, so it never toggles within a step
    task automatic sender_gap();
        int gap;
        gap = steady_flow ? 0 : pick_pause();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // result side: runs of ready with random stalls between them
    initial
    begin : result_sink
        int run_len;
        int stall_len;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            run_len = $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall_len = steady_flow ? 0 : pick_pause();
            if (stall_len != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall_len) @(posedge clk);
            end
        end
    end

    // compare each accepted result with the oldest queued pose
    always @(posedge clk)
    begin : check_results
        pose_res_t got;
        pose_res_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {new_x, new_y, new_heading, clipped};
            if (expected_poses.size() == 0)
            begin
                if (mismatch_count < MAX_REPORTS)
                begin
                    $display("ERROR: result with no request pending: x=%0d y=%0d hd=%0d clip=%0b",
                             got.new_x, got.new_y, got.new_heading, got.clipped);
                end
                mismatch_count++;
            end
            else
            begin
                want = expected_poses.pop_front();
                results_checked++;
                if (got.clipped)
                begin
                    clip_count++;
                end
                if (got !== want)
                begin
                    if (mismatch_count < MAX_REPORTS)
                    begin
                        $display("ERROR: result %0d mismatch", results_checked);
                        $display("  expected x=%0d y=%0d hd=%0d clip=%0b",
                                 want.new_x, want.new_y, want.new_heading, want.clipped);
                        $display("  actual   x=%0d y=%0d hd=%0d clip=%0b",
                                 got.new_x, got.new_y, got.new_heading, got.clipped);
                    end
                    mismatch_count++;
                end
            end
        end
    end

    // cycles since the last transfer on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : watchdog
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
        end
        $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, expected_poses.size());
        $display("planar_odometry_pose_compose test failed");
        $finish;
    end

    initial
    begin : stimulus
        directed_row_t rows[$];
        pose_req_t     req;
        int            mode;

        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        start_x       <= '0;
        start_y       <= '0;
        start_heading <= '0;
        move_forward  <= '0;
        move_lateral  <= '0;
        turn_angle    <= '0;
        steady_flow    = 1'b0;

        // Hand-typed rows: zero motion passes the start through exactly,
        // heading wrap at +/-pi, and both rails driven far past saturation
        // where the small CORDIC residue cannot matter.
        rows.push_back({mk_req(0, 0, 0, 0, 0, 0), 1'b1, mk_res(0, 0, 0, 1'b0)});
        rows.push_back({mk_req(POS_MAX, POS_MIN, 0, 0, 0, 0), 1'b1,
                        mk_res(POS_MAX, POS_MIN, 0, 1'b0)});
        rows.push_back({mk_req(POS_MIN, POS_MAX, -16'sd32768, 0, 0, -16'sd32768), 1'b1,
                        mk_res(POS_MIN, POS_MAX, 0, 1'b0)});
        rows.push_back({mk_req(12345, -54321, 16'sd32767, 0, 0, 1), 1'b1,
                        mk_res(12345, -54321, -16'sd32768, 1'b0)});
        rows.push_back({mk_req(-1, 1, -16'sd32768, 0, 0, -1), 1'b1,
                        mk_res(-1, 1, 16'sd32767, 1'b0)});
        rows.push_back({mk_req(POS_MAX, POS_MAX, 0, POS_MAX, POS_MAX, 0), 1'b1,
                        mk_res(POS_MAX, POS_MAX, 0, 1'b1)});
        rows.push_back({mk_req(POS_MIN, POS_MIN, 0, POS_MIN, POS_MIN, 0), 1'b1,
                        mk_res(POS_MIN, POS_MIN, 0, 1'b1)});
        // heading pi: cos is -1, sin is 0, so both axes run off their rails
        rows.push_back({mk_req(POS_MAX, POS_MIN, -16'sd32768, POS_MIN, POS_MAX, 16'sd16384),
                        1'b1, mk_res(POS_MAX, POS_MIN, -16'sd16384, 1'b1)});
        // the rest go through the predictor: quadrant edges, extremes, rounding
        rows.push_back({mk_req(0, 0, 0, 65536, 0, 0), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, 16'sd16384, 65536, 32768, 5), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, -16'sd16384, 65536, 32768, -5), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(100, -100, 16'sd16383, 1 << 20, -(1 << 20), 0), 1'b0,
                        pose_res_t'(0)});
        rows.push_back({mk_req(-100, 100, -16'sd16385, 1 << 20, -(1 << 20), 0), 1'b0,
                        pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, 16'sd8192, POS_MAX, 0, 16'sd8192), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, -16'sd8192, POS_MIN, POS_MIN, 0), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, 16'sd24576, POS_MAX, POS_MAX, 0), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(POS_MAX, POS_MIN, 16'sd32767, 1, -1, 16'sd32767), 1'b0,
                        pose_res_t'(0)});
        rows.push_back({mk_req(POS_MIN, POS_MAX, -1, POS_MIN, POS_MAX, -1), 1'b0,
                        pose_res_t'(0)});
        rows.push_back({mk_req(7, -7, 1, 3, -3, 1), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(0, 0, 16'sd16384, POS_MIN, POS_MAX, 0), 1'b0, pose_res_t'(0)});
        rows.push_back({mk_req(1000, -1000, -16'sd32768, 32768, -32768, 16'sd12345), 1'b0,
                        pose_res_t'(0)});
        rows.push_back({mk_req(-77777, 88888, 16'sd21845, 3 << 16, -(5 << 16), -16'sd21845),
                        1'b0, pose_res_t'(0)});

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            issue_request(rows[i].req, rows[i].known ? rows[i].want : compose_pose(rows[i].req));
            sender_gap();
        end
        directed_count = requests_sent;

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            // a stretch of every 200 requests runs with no gaps on either side
            steady_flow = (n % 200) >= 150;

            // once, hold off until the pipeline has drained completely
            if (n == RANDOM_REQUESTS / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_poses.size() != 0)
                begin
                    @(posedge clk);
                end
            end

            req.start_x       = $urandom;
            req.start_y       = $urandom;
            req.start_heading = ANG_W'($urandom);
            req.move_forward  = $urandom;
            req.move_lateral  = $urandom;
            req.turn_angle    = ANG_W'($urandom);
            mode = $urandom_range(0, 9);
            case (mode)
                4, 5, 6:
                begin
                    // typical particle: moderate position, small step
                    req.start_x      = $signed(req.start_x) >>> 7;
                    req.start_y      = $signed(req.start_y) >>> 7;
                    req.move_forward = $signed(req.move_forward) >>> 14;
                    req.move_lateral = $signed(req.move_lateral) >>> 14;
                end
                7, 8:
                begin
                    // close to a rail so small steps may or may not clip
                    req.start_x = $urandom_range(0, 1) ?
                                  POS_MAX - POS_W'($urandom_range(0, 1 << 20)) :
                                  POS_MIN + POS_W'($urandom_range(0, 1 << 20));
                    req.start_y = $urandom_range(0, 1) ?
                                  POS_MAX - POS_W'($urandom_range(0, 1 << 20)) :
                                  POS_MIN + POS_W'($urandom_range(0, 1 << 20));
                    req.move_forward = $signed(req.move_forward) >>> $urandom_range(8, 20);
                    req.move_lateral = $signed(req.move_lateral) >>> $urandom_range(8, 20);
                end
                9:
                begin
                    // heading within a few codes of a quadrant boundary
                    req.start_heading = ANG_W'($urandom_range(0, 3) * (1 << (ANG_W - 2))
                                               + $urandom_range(0, 8) - 4);
                    req.move_forward  = $signed(req.move_forward) >>> $urandom_range(0, 16);
                    req.move_lateral  = $signed(req.move_lateral) >>> $urandom_range(0, 16);
                end
                default:
                begin
                    // fully random fields as drawn
                end
            endcase

            issue_request(req, compose_pose(req));
            sender_gap();
        end
        steady_flow = 1'b0;

        in_valid <= 1'b0;
        while (expected_poses.size() != 0)
        begin
            @(posedge clk);
        end
        // catch any stray result still in the pipeline
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d pose requests (%0d from the directed table, %0d random);",
                 requests_sent, directed_count, requests_sent - directed_count);
        $display("checked %0d results, %0d of them saturated, %0d mismatches.",
                 results_checked, clip_count, mismatch_count);
        if (mismatch_count == 0 && expected_poses.size() == 0)
        begin
            $display("planar_odometry_pose_compose test passed");
        end
        else
        begin
            $display("planar_odometry_pose_compose test failed");
        end
        $finish;
    end

endmodule
